>>> rtl/fully_connected_layer_defines.svh
// assertion macros for the fully connected layer
// expects clk_i and rst_ni in the scope of the including module
`ifndef FULLY_CONNECTED_LAYER_DEFINES_SVH
`define FULLY_CONNECTED_LAYER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FCL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the cycle after
`define FCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fcl_pkg.sv
// shared types, constants and helpers for the fully connected layer
// no dependencies; imported by every rtl module of the block
package fcl_pkg;

  localparam int MAX_IN  = 64;
  localparam int MAX_OUT = 64;

  localparam int COL_W   = $clog2(MAX_IN);
  localparam int ROW_W   = $clog2(MAX_OUT);
  localparam int WADDR_W = $clog2(MAX_IN * MAX_OUT);
  localparam int CNT_W   = 7;
  localparam int SV_W    = 16;
  localparam int BIAS_W  = 32;
  localparam int PROD_W  = 2 * SV_W;
  localparam int ACC_W   = 48;
  localparam int FRAC_W  = 12;

  typedef enum logic [1:0] {
    FUNC_WEIGHT  = 2'd0,
    FUNC_BIAS    = 2'd1,
    FUNC_FEATURE = 2'd2
  } func_e;

  typedef enum logic {
    CFG_IN_COUNT  = 1'b0,
    CFG_OUT_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT_RD,
    ST_OUT_CALC,
    ST_OUT_WAIT
  } fcl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             ld_weight;
    logic             ld_bias;
    logic             feat_latch;
    logic             mac_issue;
    logic             out_load;
    logic             out_last;
    logic             acc_clear;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } fcl_cmd_t;

  // zero reads as one, anything above the limit reads as the limit
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/fcl_ctrl.sv
// controller of the fully connected layer: item sequencing, row and feature counters
// depends on fcl_pkg
module fcl_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [1:0]                 func_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic [fcl_pkg::CNT_W-1:0]  n_in_i,
  input  logic [fcl_pkg::CNT_W-1:0]  n_out_i,
  input  logic                       pipe_busy_i,
  output fcl_pkg::fcl_cmd_t          cmd_o
);
  import fcl_pkg::*;

  fcl_state_e       state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] fcnt_q, fcnt_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             vec_end_q, vec_end_d;

  logic             in_acc;
  logic             row_last;
  logic             feat_end;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign row_last = (CNT_W'(row_q) == n_out_i - CNT_W'(1));
  assign feat_end = (CNT_W'(fcnt_q) + CNT_W'(1) >= n_in_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_q     <= '0;
      fcnt_q    <= '0;
      col_q     <= '0;
      vec_end_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      fcnt_q    <= fcnt_d;
      col_q     <= col_d;
      vec_end_q <= vec_end_d;
    end
  end

  // next state
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    fcnt_d    = fcnt_q;
    col_d     = col_q;
    vec_end_d = vec_end_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (func_i == FUNC_FEATURE)) begin
          col_d     = fcnt_q;
          vec_end_d = feat_end;
          fcnt_d    = feat_end ? '0 : fcnt_q + COL_W'(1);
          row_d     = '0;
          state_d   = ST_MAC;
        end
      end
      ST_MAC: begin
        if (row_last) begin
          row_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy_i) begin
          state_d = vec_end_q ? ST_OUT_RD : ST_IDLE;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_CALC;
      end
      ST_OUT_CALC: begin
        state_d = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (!out_stall_i) begin
          if (row_last) begin
            row_d   = '0;
            state_d = ST_IDLE;
          end else begin
            row_d   = row_q + ROW_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.row   = row_q;
    cmd_o.col   = col_q;
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT_WAIT);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_i)
            FUNC_WEIGHT:  cmd_o.ld_weight  = 1'b1;
            FUNC_BIAS:    cmd_o.ld_bias    = 1'b1;
            FUNC_FEATURE: cmd_o.feat_latch = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
      end
      ST_OUT_CALC: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = row_last;
      end
      ST_OUT_WAIT: begin
        cmd_o.acc_clear = !out_stall_i && row_last;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/fcl_dpath.sv
// datapath of the fully connected layer: weight, bias and accumulator memories,
// pipelined multiply-accumulate and the result stage; depends on fcl_pkg
module fcl_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fcl_pkg::fcl_cmd_t                 cmd_i,
  input  logic [5:0]                        row_i,
  input  logic [5:0]                        col_i,
  input  logic signed [fcl_pkg::SV_W-1:0]   small_value_i,
  input  logic signed [fcl_pkg::BIAS_W-1:0] bias_value_i,
  output logic                              pipe_busy_o,
  output logic [5:0]                        out_index_o,
  output logic signed [fcl_pkg::BIAS_W-1:0] out_value_o,
  output logic                              last_o
);
  import fcl_pkg::*;

  localparam int SHIFT_W = ACC_W - FRAC_W;
  localparam int SUM_W   = SHIFT_W + 1;

  logic signed [SV_W-1:0]   weight_mem [MAX_IN*MAX_OUT];
  logic signed [BIAS_W-1:0] bias_mem   [MAX_OUT];
  logic signed [ACC_W-1:0]  acc_mem    [MAX_OUT];
  logic [MAX_OUT-1:0]       accv_q;

  logic [WADDR_W-1:0]       ld_addr, rd_addr;
  logic                     ld_in_range;

  logic signed [SV_W-1:0]   feat_q;
  logic signed [SV_W-1:0]   w_rd_q;
  logic signed [ACC_W-1:0]  acc_rd_q;
  logic                     acc_rdv_q;
  logic signed [BIAS_W-1:0] bias_rd_q;

  logic                     s1_v_q, s2_v_q;
  logic [ROW_W-1:0]         s1_row_q, s2_row_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_s2_q;
  logic signed [ACC_W-1:0]  acc_eff;
  logic signed [ACC_W-1:0]  acc_new;

  logic signed [SHIFT_W-1:0] acc_sh;
  logic signed [SUM_W-1:0]   res_sum;
  logic signed [BIAS_W-1:0]  res_sat;

  logic [5:0]               out_index_q;
  logic signed [BIAS_W-1:0] out_value_q;
  logic                     last_q;

  assign ld_in_range = (int'(row_i) < MAX_OUT) && (int'(col_i) < MAX_IN);
  assign ld_addr = WADDR_W'(row_i) * WADDR_W'(MAX_IN) + WADDR_W'(col_i);
  assign rd_addr = WADDR_W'(cmd_i.row) * WADDR_W'(MAX_IN) + WADDR_W'(cmd_i.col);

  // weight memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_weight && ld_in_range) begin
      weight_mem[ld_addr] <= small_value_i;
    end
    w_rd_q <= weight_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_bias && (int'(row_i) < MAX_OUT)) begin
      bias_mem[ROW_W'(row_i)] <= bias_value_i;
    end
    bias_rd_q <= bias_mem[cmd_i.row];
  end

  // accumulator memory, written from the last mac stage
  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      acc_mem[s2_row_q] <= acc_new;
    end
    acc_rd_q <= acc_mem[cmd_i.row];
  end

  // an entry without its valid bit reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accv_q    <= '0;
      acc_rdv_q <= 1'b0;
    end else begin
      acc_rdv_q <= accv_q[cmd_i.row];
      if (cmd_i.acc_clear) begin
        accv_q <= '0;
      end else if (s2_v_q) begin
        accv_q[s2_row_q] <= 1'b1;
      end
    end
  end

  assign acc_eff = acc_rdv_q ? acc_rd_q : '0;
  assign acc_new = acc_s2_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.mac_issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.feat_latch) begin
      feat_q <= small_value_i;
    end
    s1_row_q <= cmd_i.row;
    s2_row_q <= s1_row_q;
    prod_q   <= w_rd_q * feat_q;
    acc_s2_q <= acc_eff;
  end

  assign pipe_busy_o = s1_v_q || s2_v_q;

  // arithmetic shift floors, then bias and saturate to 32 bits
  assign acc_sh  = acc_eff[ACC_W-1:FRAC_W];
  assign res_sum = {acc_sh[SHIFT_W-1], acc_sh}
                 + {{(SUM_W-BIAS_W){bias_rd_q[BIAS_W-1]}}, bias_rd_q};

  always_comb begin
    if (res_sum[SUM_W-1:BIAS_W-1] == '0 || res_sum[SUM_W-1:BIAS_W-1] == '1) begin
      res_sat = res_sum[BIAS_W-1:0];
    end else if (res_sum[SUM_W-1]) begin
      res_sat = {1'b1, {(BIAS_W-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(BIAS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_q <= 6'(cmd_i.row);
      out_value_q <= res_sat;
      last_q      <= cmd_i.out_last;
    end
  end

  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

endmodule

>>> rtl/fully_connected_layer.sv
// top level of the fully connected layer: count registers, controller and datapath
// depends on fcl_pkg, fcl_ctrl, fcl_dpath and fully_connected_layer_defines.svh
`include "fully_connected_layer_defines.svh"

// Fixed-point fully connected layer, y = W.x + b. Weight and bias loads are written
// to their memories when taken. For a feature item, every active row passes
// once through a single shared three-stage multiply-accumulate, fed from the
// weight and accumulator memories one row per cycle, and the pipeline drains
// before the next item is taken. The feature that ends a vector is followed by
// one result per active row, each through memory read, bias add and saturate,
// and hand-over, which waits while the output is stalled. No item is taken while
// results are pending. Count registers read as 1 when zero and are capped at 64.
module fully_connected_layer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [5:0]          row_i,
  input  logic [5:0]          col_i,
  input  logic signed [15:0]  small_value_i,
  input  logic signed [31:0]  bias_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          out_index_o,
  output logic signed [31:0]  out_value_o,
  output logic                last_o
);
  import fcl_pkg::*;

  logic [CNT_W-1:0] in_count_q, out_count_q;
  logic [CNT_W-1:0] n_in, n_out;
  logic             pipe_busy;
  fcl_cmd_t         cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= CNT_W'(MAX_IN);
      out_count_q <= CNT_W'(MAX_OUT);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_IN_COUNT:  in_count_q  <= cfg_wdata_i;
        CFG_OUT_COUNT: out_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign n_in  = clamp_cnt(in_count_q, CNT_W'(MAX_IN));
  assign n_out = clamp_cnt(out_count_q, CNT_W'(MAX_OUT));

  fcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .n_in_i      (n_in),
    .n_out_i     (n_out),
    .pipe_busy_i (pipe_busy),
    .cmd_o       (cmd)
  );

  fcl_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .row_i         (row_i),
    .col_i         (col_i),
    .small_value_i (small_value_i),
    .bias_value_i  (bias_value_i),
    .pipe_busy_o   (pipe_busy),
    .out_index_o   (out_index_o),
    .out_value_o   (out_value_o),
    .last_o        (last_o)
  );

  `FCL_ASSERT_SAME(a_no_input_during_results, out_valid_o, in_stall_o, "item taken while a result is pending")
  `FCL_ASSERT_SAME(a_index_in_range, out_valid_o, (CNT_W'(out_index_o) < n_out), "result row beyond out_count")
  `FCL_ASSERT_SAME(a_last_on_final_row, out_valid_o && last_o, (CNT_W'(out_index_o) == n_out - CNT_W'(1)), "last flag on a row that is not final")
  `FCL_ASSERT_NEXT(a_idle_after_last, out_valid_o && !out_stall_i && last_o, !out_valid_o && !in_stall_o, "block not idle after final result")

endmodule
